/* sv/sorted_unique_key_table_assert.svh */
// Assertion macros for the sorted unique-key table.
`ifndef SORTED_UNIQUE_KEY_TABLE_ASSERT_SVH
`define SORTED_UNIQUE_KEY_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SUKT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_unique_key_table: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SUKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_unique_key_table: next-cycle check failed");

`endif

/* sv/sukt_pkg.sv */
// Shared types, sizes and status codes of the sorted unique-key table.
package sukt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 16;
  localparam int COUNT_OUT_W = 7;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_DUP      = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } entry_t;

  // Request from the sequencer to the record store.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

  // Outcome of one key comparison.
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

/* sv/sukt_in_if.sv */
// Request channel: operation, key and payload with valid/ready handshake.
interface sukt_in_if;
  import sukt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [KEY_W-1:0] key;
  logic [PAY_W-1:0]        payload;

  modport source (output valid, output op, output key, output payload, input ready);
  modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

/* sv/sukt_out_if.sv */
// Result channel: status and entry count with valid/ready handshake.
interface sukt_out_if;
  import sukt_pkg::*;

  logic                   valid;
  logic                   ready;
  status_t                status;
  logic [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

/* sv/sukt_store.sv */
// Record store: one read port with registered data and one write port.
module sukt_store (
  input  logic              clk,
  input  sukt_pkg::mem_req_t req,
  output sukt_pkg::entry_t   rd_data
);
  import sukt_pkg::*;

  entry_t mem [CAPACITY];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end
endmodule

/* sv/sukt_cmp.sv */
// Shared signed key comparator used by the table walk.
module sukt_cmp (
  input  logic signed [31:0] stored_key,
  input  logic signed [31:0] probe_key,
  output sukt_pkg::cmp_res_t res
);
  import sukt_pkg::*;

  // Equal means a hit; greater marks the first entry above the probe.
  always_comb begin
    res.eq = (stored_key == probe_key);
    res.gt = (stored_key > probe_key);
  end
endmodule

/* sv/sorted_unique_key_table.sv */
// Top level of the sorted unique-key table: sequencer, store and comparator.
//
// The table holds up to CAPACITY records in ascending signed key order in a
// single-port-read, single-port-write memory. Each request walks the table
// from index 0 through the shared comparator, reading and then comparing
// each entry looked at, and stops at the first entry whose key is equal to
// or above the request key. A successful insert then moves every later
// entry up and a successful remove moves every later entry down, reading
// and then writing each moved entry. A new request is taken only when the
// previous one has finished; the result sits in an output register, so a
// request may be taken while the last result waits. Key and payload
// contents are undefined after reset; only entries below the current count
// are ever read.
module sorted_unique_key_table (
  input  logic      clk,
  input  logic      rst_n,
  sukt_in_if.sink   in_chan,
  sukt_out_if.source out_chan
);
  import sukt_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_DECIDE   = 4'd3;
  localparam logic [3:0] S_INS_RD   = 4'd4;
  localparam logic [3:0] S_INS_WR   = 4'd5;
  localparam logic [3:0] S_DEL_RD   = 4'd6;
  localparam logic [3:0] S_DEL_WR   = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;

  logic [3:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        ptr_r, ptr_nxt;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic                    hit_r, hit_nxt;
  logic [CNT_W-1:0]        occ_r, occ_nxt;
  status_t                 status_r, status_nxt;
  logic                    op_r;
  logic signed [KEY_W-1:0] key_r;
  logic [PAY_W-1:0]        payload_r;
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [COUNT_OUT_W-1:0]  out_count_r;

  logic                    in_fire;
  logic                    out_load;
  logic [CNT_W-1:0]        ptr_dec;
  logic [CNT_W-1:0]        ptr_inc;
  mem_req_t                mem_req;
  entry_t                  rd_data;
  cmp_res_t                cmp_res;

  sukt_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  sukt_cmp u_cmp (
    .stored_key (rd_data.key),
    .probe_key  (key_r),
    .res        (cmp_res)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign ptr_dec       = ptr_r - CNT_W'(1);
  assign ptr_inc       = ptr_r + CNT_W'(1);
  assign out_load      = (state_r == S_FIN) && (!out_valid_r || out_chan.ready);

  // Sequencer: walk, decide, shift, report.
  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    pos_nxt    = pos_r;
    hit_nxt    = hit_r;
    occ_nxt    = occ_r;
    status_nxt = status_r;
    mem_req    = '0;
    mem_req.wr_data.key     = key_r;
    mem_req.wr_data.payload = payload_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ptr_nxt   = '0;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (ptr_r == occ_r) begin
          // Walked past the last record: key absent, place at the end.
          hit_nxt   = 1'b0;
          pos_nxt   = ptr_r;
          state_nxt = S_DECIDE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ptr_r[IDX_W-1:0];
          state_nxt       = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (cmp_res.eq || cmp_res.gt) begin
          hit_nxt   = cmp_res.eq;
          pos_nxt   = ptr_r;
          state_nxt = S_DECIDE;
        end else begin
          ptr_nxt   = ptr_inc;
          state_nxt = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        if (op_r == OP_INSERT) begin
          if (hit_r) begin
            status_nxt = ST_DUP;
            state_nxt  = S_FIN;
          end else if (occ_r == CNT_W'(CAPACITY)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_FIN;
          end else begin
            ptr_nxt   = occ_r;
            state_nxt = S_INS_RD;
          end
        end else begin
          if (!hit_r) begin
            status_nxt = ST_NOTFOUND;
            state_nxt  = S_FIN;
          end else begin
            ptr_nxt   = pos_r;
            state_nxt = S_DEL_RD;
          end
        end
      end
      S_INS_RD: begin
        if (ptr_r == pos_r) begin
          // Gap is open: drop the new record in.
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = ptr_r[IDX_W-1:0];
          occ_nxt         = occ_r + CNT_W'(1);
          status_nxt      = ST_OK;
          state_nxt       = S_FIN;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ptr_dec[IDX_W-1:0];
          state_nxt       = S_INS_WR;
        end
      end
      S_INS_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = ptr_r[IDX_W-1:0];
        mem_req.wr_data = rd_data;
        ptr_nxt         = ptr_dec;
        state_nxt       = S_INS_RD;
      end
      S_DEL_RD: begin
        if (ptr_inc == occ_r) begin
          occ_nxt    = occ_r - CNT_W'(1);
          status_nxt = ST_OK;
          state_nxt  = S_FIN;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ptr_inc[IDX_W-1:0];
          state_nxt       = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = ptr_r[IDX_W-1:0];
        mem_req.wr_data = rd_data;
        ptr_nxt         = ptr_inc;
        state_nxt       = S_DEL_RD;
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // Working registers of the current transaction.
  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    pos_r    <= pos_nxt;
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
    if (in_fire) begin
      op_r      <= in_chan.op;
      key_r     <= in_chan.key;
      payload_r <= in_chan.payload;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      out_count_r  <= COUNT_OUT_W'(occ_r);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.entry_count = out_count_r;

`include "sorted_unique_key_table_assert.svh"

  // The record count never exceeds the table size.
  `SUKT_ASSERT_SAME(a_occ_bound, clk, rst_n, 1'b1, occ_r <= CNT_W'(CAPACITY))
  // An accepted request always starts the table walk.
  `SUKT_ASSERT_NEXT(a_start_walk, clk, rst_n, in_fire, state_r == S_SCAN_RD)
  // The store is written only while records move or the new one lands.
  `SUKT_ASSERT_SAME(a_wr_phase, clk, rst_n, mem_req.wr_en,
    state_r == S_INS_RD || state_r == S_INS_WR || state_r == S_DEL_WR)
  // The count holds while no request is in progress.
  `SUKT_ASSERT_NEXT(a_idle_count, clk, rst_n, state_r == S_IDLE, $stable(occ_r))
endmodule

/* tb/sv/sorted_unique_key_table_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the sorted unique-key table with a shadow table predictor.
module sorted_unique_key_table_tb;
  import sukt_pkg::*;

  // Longest wait with no transaction on either channel before the run is aborted.
  // It is well above both the longest operation and the long receiver hold-off.
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_LEN    = 300;
  localparam int DRAIN_WAIT  = 2 * CAPACITY + 20;
  localparam int POOL_N      = 96;

  typedef struct {
    logic                    op;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } table_req_t;

  typedef struct {
    status_t                status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } table_resp_t;

  logic clk;
  logic rst_n;

  sukt_in_if  in_if ();
  sukt_out_if out_if ();

  sorted_unique_key_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Shadow copy of the table contents, kept in ascending key order.
  entry_t      shadow_table[$];
  table_req_t  pending_reqs[$];
  table_resp_t awaited_results[$];

  int queued_cnt;
  int accepted_cnt = 0;
  int error_cnt = 0;
  int src_idle_pct;
  int snk_stall_pct;
  int hold_token;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  logic signed [KEY_W-1:0] key_pool[POOL_N];

  // Applies one operation to the shadow table and returns the expected result.
  function automatic table_resp_t apply_table_op(table_req_t req);
    table_resp_t resp;
    entry_t      rec;
    int          hit;
    int          place;
    hit = -1;
    foreach (shadow_table[i]) begin
      if (shadow_table[i].key == req.key && hit < 0) hit = i;
    end
    if (req.op == OP_INSERT) begin
      if (hit >= 0) begin
        resp.status = ST_DUP;
      end else if (shadow_table.size() >= CAPACITY) begin
        resp.status = ST_FULL;
      end else begin
        place = shadow_table.size();
        for (int i = shadow_table.size() - 1; i >= 0; i--) begin
          if ($signed(req.key) < $signed(shadow_table[i].key)) place = i;
        end
        rec.key     = req.key;
        rec.payload = req.payload;
        shadow_table.insert(place, rec);
        resp.status = ST_OK;
      end
    end else begin
      if (hit < 0) begin
        resp.status = ST_NOTFOUND;
      end else begin
        shadow_table.delete(hit);
        resp.status = ST_OK;
      end
    end
    resp.entry_count = COUNT_OUT_W'(shadow_table.size());
    return resp;
  endfunction

  // Clock and reset.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Request driver: predicts each accepted transaction and offers the next one.
  always @(posedge clk) begin : req_driver
    table_req_t nxt;
    table_req_t cur;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        cur.op = in_if.op;
        cur.key = in_if.key;
        cur.payload = in_if.payload;
        awaited_results.push_back(apply_table_op(cur));
        accepted_cnt++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = pending_reqs.pop_front();
          in_if.valid <= 1'b1;
          in_if.op <= nxt.op;
          in_if.key <= nxt.key;
          in_if.payload <= nxt.payload;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result transaction and drives ready.
  always @(posedge clk) begin : resp_monitor
    table_resp_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d entry_count=%0d", $time,
                   out_if.status, out_if.entry_count);
          error_cnt++;
        end else begin
          want = awaited_results.pop_front();
          if (out_if.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     want.status, out_if.status);
            error_cnt++;
          end
          if (out_if.entry_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch, expected %0d, actual %0d", $time,
                     want.entry_count, out_if.entry_count);
            error_cnt++;
          end
        end
      end
      // A new hold request starts a long stretch with ready low.
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Watchdog: aborts when neither channel completes a transaction for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic add_req(logic op, logic signed [KEY_W-1:0] key, logic [PAY_W-1:0] payload);
    table_req_t req;
    req.op = op;
    req.key = key;
    req.payload = payload;
    pending_reqs.push_back(req);
    queued_cnt++;
  endtask

  // Waits until every queued request has been taken and answered.
  task automatic wait_all_answered();
    do @(negedge clk);
    while (accepted_cnt != queued_cnt || awaited_results.size() != 0);
  endtask

  // One stretch of random traffic. Removes mostly use pooled keys so that they
  // hit; inserts mix pooled keys (duplicates) with fresh full-range keys.
  task automatic run_phase(int src_pct, int snk_pct, int num, int ins_pct, bit hold);
    logic op;
    logic signed [KEY_W-1:0] key;
    @(negedge clk);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    for (int n = 0; n < num; n++) begin
      op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
      if ($urandom_range(99) < ((op == OP_REMOVE) ? 90 : 50)) begin
        key = key_pool[$urandom_range(POOL_N - 1)];
      end else begin
        key = $urandom;
      end
      add_req(op, key, PAY_W'($urandom_range(16'hFFFF)));
    end
    if (hold) hold_token++;
    wait_all_answered();
  endtask

  // Stimulus sequence.
  initial begin
    queued_cnt = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_token = 0;
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7FFF_FFFF;
    key_pool[2] = 0;
    key_pool[3] = -1;
    key_pool[4] = 1;
    for (int i = 5; i < POOL_N; i++) key_pool[i] = $urandom;
    @(posedge rst_n);

    // Directed: empty table, key extremes, duplicates, misses, head/tail/middle removes.
    add_req(OP_REMOVE, 5, 16'h0000);
    add_req(OP_INSERT, 0, 16'h1234);
    add_req(OP_INSERT, 32'sh7FFF_FFFF, 16'hFFFF);
    add_req(OP_INSERT, 32'sh8000_0000, 16'h0000);
    add_req(OP_INSERT, -1, 16'hA5A5);
    add_req(OP_INSERT, 1, 16'h5A5A);
    add_req(OP_INSERT, 0, 16'hFFFF);
    add_req(OP_INSERT, 32'sh7FFF_FFFF, 16'h0001);
    add_req(OP_REMOVE, 7, 16'hFFFF);
    add_req(OP_REMOVE, 32'sh8000_0000, 16'h0000);
    add_req(OP_REMOVE, 32'sh7FFF_FFFF, 16'h0000);
    add_req(OP_REMOVE, 0, 16'h0000);
    add_req(OP_INSERT, 32'sh8000_0000, 16'h8000);
    add_req(OP_REMOVE, -1, 16'h0000);
    add_req(OP_REMOVE, 1, 16'h0000);
    add_req(OP_REMOVE, 32'sh8000_0000, 16'h0000);
    add_req(OP_REMOVE, 1, 16'h0000);
    wait_all_answered();

    // Random: fill to capacity, drain, and refill under each idling pattern.
    run_phase(0, 0, 170, 90, 1'b0);
    run_phase(82, 0, 160, 30, 1'b0);
    run_phase(0, 0, 120, 60, 1'b1);
    run_phase(0, 82, 160, 85, 1'b0);
    run_phase(34, 34, 160, 50, 1'b0);
    run_phase(0, 0, 160, 20, 1'b0);

    repeat (DRAIN_WAIT) @(negedge clk);
    if (error_cnt == 0 && awaited_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
